FILE: hdl/hrsu_pkg.sv
// Shared types, constants and helper functions for the rank-register sketch block.
`timescale 1ns / 1ps

package hrsu_pkg;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int HASH_W    = 32;
  localparam int IDX_W     = 16;
  localparam int RANK_W    = 6;
  localparam int PREC_W    = 5;
  localparam int ZERO_W    = 17;
  localparam int SUM_W     = 49;
  localparam int FRAC_BITS = 32;

  // Default for the largest supported precision
  localparam int MAX_PRECISION_DEF = 16;

  // APB register file
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_PRECISION_IDX = 1'b0;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd2;

  localparam logic [RANK_W-1:0] RANK_CAP = 6'd32;
  localparam logic [PREC_W-1:0] PREC_MIN = 5'd2;

  // Population count masks
  localparam logic [31:0] POP_M1  = 32'h5555_5555;
  localparam logic [31:0] POP_M2  = 32'h3333_3333;
  localparam logic [31:0] POP_M4  = 32'h0F0F_0F0F;
  localparam logic [31:0] POP_OUT = 32'h0000_003F;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [HASH_W-1:0] item_hash;
    logic [IDX_W-1:0]  register_index;
    logic [RANK_W-1:0] rank_value;
  } item_t;

  typedef struct packed {
    logic              status;
    logic              changed;
    logic [IDX_W-1:0]  touched_index;
    logic [RANK_W-1:0] touched_rank;
    logic [ZERO_W-1:0] zero_count;
    logic [SUM_W-1:0]  harmonic_sum;
  } result_t;

  // Control from the sequencer to the tally keeper
  typedef struct packed {
    logic              clear;
    logic [PREC_W-1:0] clear_k;
    logic              commit;
    logic [RANK_W-1:0] old_rank;
    logic [RANK_W-1:0] new_rank;
    logic [PREC_W-1:0] precision;
  } tally_ctl_t;

  // Count leading zeros of a 32-bit word: smear ones right, then count them
  function automatic logic [RANK_W-1:0] lead_zeros(input logic [31:0] v);
    logic [31:0] s;
    logic [31:0] c;
    s = v | (v >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    s = s | (s >> 16);
    c = s - ((s >> 1) & POP_M1);
    c = ((c >> 2) & POP_M2) + (c & POP_M2);
    c = ((c >> 4) + c) & POP_M4;
    c = c + (c >> 8);
    c = c + (c >> 16);
    lead_zeros = RANK_W'(FRAC_BITS) - RANK_W'(c & POP_OUT);
  endfunction

  // Weight 2^-rank in 17.32 fixed point, rank saturated at the cap
  function automatic logic [SUM_W-1:0] weight_of(input logic [RANK_W-1:0] r);
    logic [RANK_W-1:0] rc;
    rc = (r > RANK_CAP) ? RANK_CAP : r;
    weight_of = {{(SUM_W-1){1'b0}}, 1'b1} << (RANK_W'(FRAC_BITS) - rc);
  endfunction

endpackage

FILE: hdl/hrsu_rank_mem.sv
// Rank store: one write port, one registered read port.
`timescale 1ns / 1ps

module hrsu_rank_mem #(
  parameter int MAX_PRECISION = hrsu_pkg::MAX_PRECISION_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [MAX_PRECISION-1:0]      rd_addr,
  output logic [hrsu_pkg::RANK_W-1:0]   rd_data,
  input  logic                          wr_en,
  input  logic [MAX_PRECISION-1:0]      wr_addr,
  input  logic [hrsu_pkg::RANK_W-1:0]   wr_data
);

  localparam int DEPTH = 1 << MAX_PRECISION;

  logic [hrsu_pkg::RANK_W-1:0] mem [0:DEPTH-1];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, hold data when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/hrsu_decode.sv
// Item decode: register index, candidate rank and range check for one word.
`timescale 1ns / 1ps

module hrsu_decode #(
  parameter int MAX_PRECISION = hrsu_pkg::MAX_PRECISION_DEF
) (
  input  hrsu_pkg::item_t               item,
  input  logic [hrsu_pkg::PREC_W-1:0]   precision,
  output logic [MAX_PRECISION-1:0]      mem_idx,
  output logic [hrsu_pkg::IDX_W-1:0]    touched_index,
  output logic [hrsu_pkg::RANK_W-1:0]   new_rank,
  output logic                          index_ok
);

  logic [hrsu_pkg::HASH_W-1:0] top_bits;
  logic [hrsu_pkg::HASH_W-1:0] low_mask;
  logic [hrsu_pkg::HASH_W-1:0] low_bits;
  logic [hrsu_pkg::RANK_W-1:0] lz;
  logic [hrsu_pkg::RANK_W-1:0] rank_sat;
  logic [hrsu_pkg::IDX_W-1:0]  ridx_high;

  // Split the hash into register index and remaining bits
  assign top_bits  = item.item_hash >> (hrsu_pkg::RANK_W'(hrsu_pkg::HASH_W) - {1'b0, precision});
  assign low_mask  = {hrsu_pkg::HASH_W{1'b1}} >> precision;
  assign low_bits  = item.item_hash & low_mask;
  assign lz        = hrsu_pkg::lead_zeros(low_bits);

  // Saturate the given rank, flag indexes at or above 2^k
  assign rank_sat  = (item.rank_value > hrsu_pkg::RANK_CAP) ? hrsu_pkg::RANK_CAP
                                                           : item.rank_value;
  assign ridx_high = item.register_index >> precision;

  always_comb begin
    case (item.func)
      hrsu_pkg::FUNC_ADD: begin
        mem_idx       = top_bits[MAX_PRECISION-1:0];
        touched_index = top_bits[hrsu_pkg::IDX_W-1:0];
        new_rank      = lz - {1'b0, precision} + hrsu_pkg::RANK_W'(1);
        index_ok      = 1'b1;
      end
      hrsu_pkg::FUNC_MERGE, hrsu_pkg::FUNC_SET: begin
        mem_idx       = item.register_index[MAX_PRECISION-1:0];
        touched_index = item.register_index;
        new_rank      = rank_sat;
        index_ok      = (ridx_high == '0);
      end
      default: begin
        mem_idx       = '0;
        touched_index = '0;
        new_rank      = '0;
        index_ok      = 1'b1;
      end
    endcase
  end

endmodule

FILE: hdl/hrsu_tally.sv
// Running zero-register count and harmonic sum, updated per register write.
`timescale 1ns / 1ps

module hrsu_tally (
  input  logic                          clk,
  input  logic                          rst,
  input  hrsu_pkg::tally_ctl_t          ctl,
  output logic [hrsu_pkg::ZERO_W-1:0]   zero_upd,
  output logic [hrsu_pkg::SUM_W-1:0]    sum_upd
);

  logic [hrsu_pkg::ZERO_W-1:0] zero_tally;
  logic [hrsu_pkg::SUM_W-1:0]  inv_sum;
  logic [hrsu_pkg::ZERO_W-1:0] zero_init;
  logic [hrsu_pkg::ZERO_W-1:0] zero_limit;

  assign zero_init  = hrsu_pkg::ZERO_W'(1) << ctl.clear_k;
  assign zero_limit = hrsu_pkg::ZERO_W'(1) << ctl.precision;

  // Values after this step: swap the old register's share for the new one
  always_comb begin
    zero_upd = zero_tally;
    sum_upd  = inv_sum;
    if (ctl.commit) begin
      zero_upd = zero_tally
               - hrsu_pkg::ZERO_W'(ctl.old_rank == '0)
               + hrsu_pkg::ZERO_W'(ctl.new_rank == '0);
      sum_upd  = inv_sum
               - hrsu_pkg::weight_of(ctl.old_rank)
               + hrsu_pkg::weight_of(ctl.new_rank);
    end
  end

  // Reload on clear, else take the updated values
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      zero_tally <= zero_init;
      inv_sum    <= hrsu_pkg::SUM_W'(zero_init) << hrsu_pkg::FRAC_BITS;
    end else begin
      zero_tally <= zero_upd;
      inv_sum    <= sum_upd;
    end
  end

  a_zero_bound: assert property (@(posedge clk) disable iff (rst)
    zero_tally <= zero_limit)
    else $error("zero tally above active register count");

  a_sum_floor: assert property (@(posedge clk) disable iff (rst)
    inv_sum >= (hrsu_pkg::SUM_W'(zero_tally) << hrsu_pkg::FRAC_BITS))
    else $error("harmonic sum below zero-register share");

  a_sum_ceiling: assert property (@(posedge clk) disable iff (rst)
    inv_sum <= (hrsu_pkg::SUM_W'(zero_limit) << hrsu_pkg::FRAC_BITS))
    else $error("harmonic sum above active register count");

endmodule

FILE: hdl/hll_register_sketch_update_top.sv
// Top level of the rank-register sketch update block.
//
//  channel  | direction | handshake                    | word
//  ---------+-----------+------------------------------+-------------------------
//  item     | in        | item_valid / item_stall      | func, hash, index, rank
//  result   | out       | result_valid / result_stall  | status, rank, tallies
//  apb      | in/out    | psel, penable, pwrite, pready| precision_bits at 0x0
//
//  An item passes through two states: the accept cycle issues the rank store read,
//  then ST_UPD modifies and writes back and loads the result register. The registered
//  read of the rank store sets this order; one item is in flight at a time.
//  After reset and after each precision write, a clearing sweep writes zero to all
//  2^MAX_PRECISION entries, one per cycle; items are stalled during the sweep.
//  A stalled result holds the update stage; the next item is taken once it loads.
`timescale 1ns / 1ps

module hll_register_sketch_update_top #(
  parameter int MAX_PRECISION = hrsu_pkg::MAX_PRECISION_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrsu_pkg::PADDR_W-1:0]   paddr,
  input  logic [hrsu_pkg::PDATA_W-1:0]   pwdata,
  output logic [hrsu_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  hrsu_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output hrsu_pkg::result_t              result
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } state_t;

  localparam logic [hrsu_pkg::PREC_W-1:0] PREC_MAX = hrsu_pkg::PREC_W'(MAX_PRECISION);

  state_t                        state;
  logic [hrsu_pkg::PREC_W-1:0]   precision;
  logic [hrsu_pkg::PREC_W-1:0]   cfg_k;
  logic                          cfg_wr;
  logic                          clearing;
  logic [MAX_PRECISION-1:0]      clear_cnt;
  logic                          accept;
  logic                          load;

  // Decode outputs
  logic [MAX_PRECISION-1:0]      dec_idx;
  logic [hrsu_pkg::IDX_W-1:0]    dec_touched;
  logic [hrsu_pkg::RANK_W-1:0]   dec_rank;
  logic                          dec_ok;

  // Item held through the update stage
  logic [hrsu_pkg::FUNC_W-1:0]   func_q;
  logic [MAX_PRECISION-1:0]      idx_q;
  logic [hrsu_pkg::IDX_W-1:0]    touched_q;
  logic [hrsu_pkg::RANK_W-1:0]   rank_q;
  logic                          ok_q;

  // Update stage
  logic [hrsu_pkg::RANK_W-1:0]   old_rank;
  logic                          do_wr;
  logic [hrsu_pkg::RANK_W-1:0]   touched_rank;
  logic                          mem_we;
  logic [MAX_PRECISION-1:0]      mem_waddr;
  logic [hrsu_pkg::RANK_W-1:0]   mem_wdata;

  hrsu_pkg::tally_ctl_t          tally_ctl;
  logic [hrsu_pkg::ZERO_W-1:0]   zero_upd;
  logic [hrsu_pkg::SUM_W-1:0]    sum_upd;

  // APB: always ready, one register at index 0
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[hrsu_pkg::PADDR_W-1] == hrsu_pkg::REG_PRECISION_IDX);
  assign prdata = (paddr[hrsu_pkg::PADDR_W-1] == hrsu_pkg::REG_PRECISION_IDX)
                ? hrsu_pkg::PDATA_W'(precision) : '0;

  // Clamp the written precision to the supported range
  always_comb begin
    cfg_k = pwdata[hrsu_pkg::PREC_W-1:0];
    if (cfg_k < hrsu_pkg::PREC_MIN) begin
      cfg_k = hrsu_pkg::PREC_MIN;
    end else if (cfg_k > PREC_MAX) begin
      cfg_k = PREC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      precision <= PREC_MAX;
    end else if (cfg_wr) begin
      precision <= cfg_k;
    end
  end

  // Clearing sweep over the whole store
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      clearing  <= 1'b1;
      clear_cnt <= '0;
    end else if (clearing) begin
      clear_cnt <= clear_cnt + 1'b1;
      if (clear_cnt == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  hrsu_decode #(
    .MAX_PRECISION(MAX_PRECISION)
  ) u_decode (
    .item          (item),
    .precision     (precision),
    .mem_idx       (dec_idx),
    .touched_index (dec_touched),
    .new_rank      (dec_rank),
    .index_ok      (dec_ok)
  );

  assign item_stall = clearing || (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign load       = (state == ST_UPD) && !clearing && (!result_valid || !result_stall);

  // Sequencer: accept, then update; a config write abandons the stage
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture the decoded word
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= item.func;
      idx_q     <= dec_idx;
      touched_q <= dec_touched;
      rank_q    <= dec_rank;
      ok_q      <= dec_ok;
    end
  end

  hrsu_rank_mem #(
    .MAX_PRECISION(MAX_PRECISION)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (dec_idx),
    .rd_data (old_rank),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  // Decide the write and the reported rank
  always_comb begin
    case (func_q)
      hrsu_pkg::FUNC_ADD: begin
        do_wr        = rank_q > old_rank;
        touched_rank = do_wr ? rank_q : old_rank;
      end
      hrsu_pkg::FUNC_MERGE: begin
        do_wr        = ok_q && (rank_q > old_rank);
        touched_rank = !ok_q ? '0 : (do_wr ? rank_q : old_rank);
      end
      hrsu_pkg::FUNC_SET: begin
        do_wr        = ok_q && (rank_q != old_rank);
        touched_rank = ok_q ? rank_q : '0;
      end
      default: begin
        do_wr        = 1'b0;
        touched_rank = '0;
      end
    endcase
  end

  // Store write: the sweep owns the port while it runs
  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_cnt;
      mem_wdata = '0;
    end else begin
      mem_we    = load && do_wr;
      mem_waddr = idx_q;
      mem_wdata = rank_q;
    end
  end

  always_comb begin
    tally_ctl.clear     = rst || cfg_wr;
    tally_ctl.clear_k   = rst ? PREC_MAX : cfg_k;
    tally_ctl.commit    = load && do_wr;
    tally_ctl.old_rank  = old_rank;
    tally_ctl.new_rank  = rank_q;
    tally_ctl.precision = precision;
  end

  hrsu_tally u_tally (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tally_ctl),
    .zero_upd (zero_upd),
    .sum_upd  (sum_upd)
  );

  // Result register: load on update, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.status        <= !ok_q;
      result.changed       <= do_wr;
      result.touched_index <= touched_q;
      result.touched_rank  <= touched_rank;
      result.zero_count    <= zero_upd;
      result.harmonic_sum  <= sum_upd;
    end
  end

  a_accept_to_upd: assert property (@(posedge clk) disable iff (rst)
    accept && !cfg_wr |=> state == ST_UPD)
    else $error("accepted word did not reach update stage");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> result_valid)
    else $error("loaded result not presented");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) && result_valid && result_stall && !cfg_wr |=> state == ST_UPD)
    else $error("update stage left while result register blocked");

  a_sweep_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> state == ST_IDLE)
    else $error("word in flight during clearing sweep");

endmodule

FILE: tb/hll_register_sketch_checker.sv
// Checker for the rank-register sketch block: predicts every result word and compares it.
`timescale 1ns / 1ps

module hll_register_sketch_checker import hrsu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               item_valid,
  input  logic               item_stall,
  input  item_t              item,
  input  logic               result_valid,
  input  logic               result_stall,
  input  result_t            result,
  output int                 fail_count,
  output int                 results_due,
  output int                 results_seen
);

  localparam logic [PADDR_W-1:0] PREC_ADDR = {REG_PRECISION_IDX, 2'b00};
  localparam int STORE_DEPTH = 1 << MAX_PRECISION_DEF;

  // Shadow copy of the sketch
  logic [RANK_W-1:0] ranks [0:STORE_DEPTH-1];
  logic [ZERO_W-1:0] zeros_now;
  logic [SUM_W-1:0]  inv_sum;
  int unsigned       k_now;

  result_t sketch_results_due[$];
  int      mismatches;
  int      words_out;

  assign fail_count   = mismatches;
  assign results_due  = sketch_results_due.size();
  assign results_seen = words_out;

  function automatic int unsigned clamp_precision(input logic [PREC_W-1:0] kw);
    if (kw < PREC_MIN) return PREC_MIN;
    if (kw > MAX_PRECISION_DEF) return MAX_PRECISION_DEF;
    return kw;
  endfunction

  // Wipe all registers and restart the tallies at 2^k zeros
  function automatic void clear_sketch(input int unsigned kw);
    for (int i = 0; i < STORE_DEPTH; i++) ranks[i] = '0;
    k_now     = kw;
    zeros_now = ZERO_W'(1) << kw;
    inv_sum   = SUM_W'(1) << (kw + FRAC_BITS);
  endfunction

  // Highest set bit wins; an all-zero word counts 32
  function automatic int unsigned count_lead_zeros(input logic [31:0] v);
    int unsigned n;
    n = 32;
    for (int b = 0; b < 32; b++) if (v[b]) n = 31 - b;
    return n;
  endfunction

  function automatic logic [SUM_W-1:0] rank_weight(input logic [RANK_W-1:0] r);
    logic [RANK_W-1:0] rc;
    rc = (r > RANK_CAP) ? RANK_CAP : r;
    return SUM_W'(1) << (FRAC_BITS - rc);
  endfunction

  // Write one register and keep the zero count and sum current
  function automatic logic store_rank(input int unsigned idx, input logic [RANK_W-1:0] r);
    logic [RANK_W-1:0] prior;
    prior = ranks[idx];
    if (prior == r) return 1'b0;
    if (prior == '0) zeros_now--;
    if (r == '0) zeros_now++;
    inv_sum    = inv_sum - rank_weight(prior) + rank_weight(r);
    ranks[idx] = r;
    return 1'b1;
  endfunction

  // Apply one word to the shadow sketch and return the result it must produce
  function automatic result_t apply_rank_update(input item_t w);
    result_t           r;
    int unsigned       active;
    int unsigned       idx;
    int unsigned       rank;
    logic [31:0]       lowbits;
    logic [RANK_W-1:0] rv;
    r      = '0;
    active = 1 << k_now;
    rv     = (w.rank_value > RANK_CAP) ? RANK_CAP : w.rank_value;
    case (w.func)
      FUNC_ADD: begin
        idx     = w.item_hash >> (32 - k_now);
        lowbits = w.item_hash & ((32'd1 << (32 - k_now)) - 32'd1);
        rank    = count_lead_zeros(lowbits) - k_now + 1;
        if (rank > ranks[idx]) r.changed = store_rank(idx, RANK_W'(rank));
        r.touched_index = IDX_W'(idx);
        r.touched_rank  = ranks[idx];
      end
      FUNC_MERGE, FUNC_SET: begin
        r.touched_index = w.register_index;
        if (w.register_index >= active) begin
          r.status = 1'b1;
        end else begin
          if (w.func == FUNC_SET || rv > ranks[w.register_index])
            r.changed = store_rank(w.register_index, rv);
          r.touched_rank = ranks[w.register_index];
        end
      end
      default: ;
    endcase
    r.zero_count   = zeros_now;
    r.harmonic_sum = inv_sum;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    words_out  = 0;
  end

  // Retire result words first, then track register writes and new words
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_sketch(clamp_precision(PREC_W'(16)));
      sketch_results_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        words_out++;
        if (sketch_results_due.size() == 0) begin
          $error("result word with no word outstanding");
          mismatches++;
        end else begin
          want = sketch_results_due.pop_front();
          check_field("status", want.status, result.status);
          check_field("changed", want.changed, result.changed);
          check_field("touched_index", want.touched_index, result.touched_index);
          check_field("touched_rank", want.touched_rank, result.touched_rank);
          check_field("zero_count", want.zero_count, result.zero_count);
          check_field("harmonic_sum", want.harmonic_sum, result.harmonic_sum);
        end
      end
      if (psel && penable && pwrite && pready && paddr == PREC_ADDR)
        clear_sketch(clamp_precision(pwdata[PREC_W-1:0]));
      if (item_valid && !item_stall)
        sketch_results_due.push_back(apply_rank_update(item));
    end
  end

endmodule

FILE: tb/tb_hll_register_sketch_update_top.sv
// Testbench top for the rank-register sketch block: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_hll_register_sketch_update_top;
  import hrsu_pkg::*;

  localparam logic [PADDR_W-1:0] PREC_ADDR   = {REG_PRECISION_IDX, 2'b00};
  localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4 * (1 << MAX_PRECISION_DEF);
  localparam int PHASE_WORDS    = 285;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [PADDR_W-1:0] paddr        = '0;
  logic [PDATA_W-1:0] pwdata       = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  item_t              item         = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  result_t            result;

  int          fail_count;
  int          results_due;
  int          results_seen;
  int unsigned cur_k = 16;
  int          burst_left = 0;
  int          func_sent [4] = '{0, 0, 0, 0};
  int          settings_run = 1;
  int          stall_left = 0;
  logic        stall_on = 1'b0;
  int          quiet_cycles = 0;

  hll_register_sketch_update_top uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  hll_register_sketch_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .results_seen (results_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stall and free runs of random length
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_on   = ($urandom_range(0, 2) == 0);
      stall_left = stall_on ? $urandom_range(1, 12) : $urandom_range(1, 40);
    end
    stall_left--;
    result_stall = stall_on;
  end

  // Watchdog: end the run after too long with no word or register write moving
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t pack_word(input logic [FUNC_W-1:0] f, input logic [HASH_W-1:0] h,
                                      input logic [IDX_W-1:0] i, input logic [RANK_W-1:0] r);
    item_t w;
    w.func           = f;
    w.item_hash      = h;
    w.register_index = i;
    w.rank_value     = r;
    return w;
  endfunction

  // Mostly well-formed updates aimed at a few hot registers, some noise
  function automatic item_t random_word();
    item_t       w;
    int unsigned pick;
    int unsigned span;
    int unsigned idx;
    logic [31:0] lowmask;
    logic [31:0] lowbits;
    w.func           = FUNC_W'($urandom_range(0, 3));
    w.item_hash      = $urandom;
    w.register_index = IDX_W'($urandom);
    w.rank_value     = RANK_W'($urandom);
    pick = $urandom_range(0, 99);
    span = 1 << cur_k;
    idx  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, (span > 8) ? 7 : span - 1)
                                       : $urandom_range(0, span - 1);
    if (pick < 50) begin
      lowmask     = (32'd1 << (32 - cur_k)) - 32'd1;
      lowbits     = 32'($urandom) >> $urandom_range(0, 32);
      w.func      = FUNC_ADD;
      w.item_hash = (32'(idx) << (32 - cur_k)) | (lowbits & lowmask);
    end else if (pick < 90) begin
      w.func = (pick < 70) ? FUNC_MERGE : FUNC_SET;
      if ($urandom_range(0, 99) < 85) w.register_index = IDX_W'(idx);
      if ($urandom_range(0, 99) < 80) w.rank_value = RANK_W'($urandom_range(0, 32));
    end else if (pick < 95) begin
      w.func = FUNC_UNUSED;
    end
    return w;
  endfunction

  // Send one word, opening a new burst after a random gap when the last one ran out
  task automatic send_item(input item_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        item_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    item_valid = 1'b1;
    item       = w;
    do @(posedge clk); while (item_stall);
    func_sent[w.func]++;
  endtask

  // Hold off the sender until every outstanding result word has come back
  task automatic drain_results();
    @(negedge clk);
    item_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic write_precision(input logic [PREC_W-1:0] kw);
    drain_results();
    repeat (4) @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PREC_ADDR;
    pwdata  = PDATA_W'(kw);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    cur_k   = (kw < PREC_MIN) ? PREC_MIN : (kw > MAX_PRECISION_DEF) ? MAX_PRECISION_DEF : kw;
    settings_run++;
  endtask

  task automatic run_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 149) == 0) drain_results();
      send_item(random_word());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset precision: hash with all-zero low bits, top index, saturating set
    send_item(pack_word(FUNC_ADD, 32'h0000_0000, '0, '0));
    send_item(pack_word(FUNC_ADD, 32'hFFFF_FFFF, '0, '0));
    send_item(pack_word(FUNC_SET, '0, 16'hFFFF, 6'd63));
    send_item(pack_word(FUNC_MERGE, '0, 16'h0000, 6'd5));

    // Below-range write clamps to the smallest precision
    write_precision(5'd0);
    send_item(pack_word(FUNC_ADD, 32'h0000_0000, '0, '0));
    send_item(pack_word(FUNC_ADD, 32'hC000_0001, '0, '0));
    send_item(pack_word(FUNC_ADD, 32'h3FFF_FFFF, '0, '0));
    send_item(pack_word(FUNC_MERGE, '0, 16'd2, 6'd0));
    send_item(pack_word(FUNC_MERGE, '0, 16'd2, 6'd7));
    send_item(pack_word(FUNC_MERGE, '0, 16'd2, 6'd3));
    send_item(pack_word(FUNC_MERGE, '0, 16'd2, 6'd40));
    send_item(pack_word(FUNC_SET, '0, 16'd2, 6'd32));
    send_item(pack_word(FUNC_SET, '0, 16'd2, 6'd0));
    send_item(pack_word(FUNC_SET, '0, 16'd4, 6'd5));
    send_item(pack_word(FUNC_MERGE, '0, 16'hFFFF, 6'd63));
    send_item(pack_word(FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 6'd63));
    send_item(pack_word(FUNC_SET, '0, 16'd1, 6'd63));
    send_item(pack_word(FUNC_ADD, 32'hFFFF_FFFF, '0, '0));
    send_item(pack_word(FUNC_SET, '0, 16'd0, 6'd0));
    send_item(pack_word(FUNC_SET, '0, 16'd3, 6'd0));
    run_phase(PHASE_WORDS);

    // Sweep precision through the extremes and a few middle settings
    write_precision(5'd31);
    run_phase(PHASE_WORDS);
    write_precision(5'd7);
    run_phase(PHASE_WORDS);
    write_precision(5'd1);
    run_phase(PHASE_WORDS);
    write_precision(5'd16);
    run_phase(PHASE_WORDS);
    write_precision(5'd11);
    run_phase(PHASE_WORDS);

    drain_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d add, %0d merge, %0d set and %0d unused-op words over %0d precision settings",
             func_sent[FUNC_ADD], func_sent[FUNC_MERGE], func_sent[FUNC_SET],
             func_sent[FUNC_UNUSED], settings_run);
    $display("Compared %0d result words against the predicted sketch", results_seen);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
